[rtl/brd_pkg.sv]
// shared types and constants of the bilinear rgb downscaler
package brd_pkg;

  // size limits
  localparam int MAX_OUT_WIDTH = 1024;
  localparam int MAX_IN_DIM    = 4096;
  localparam int LS_AW         = $clog2(MAX_OUT_WIDTH);

  // configuration register indexes
  localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_X_STEP     = 3'd4;
  localparam logic [2:0] REG_Y_STEP     = 3'd5;

  typedef logic [23:0] pixel_t;

  // input transaction
  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
  } brd_in_t;

  // output transaction
  typedef struct packed {
    logic [9:0] dst_col;
    logic [9:0] dst_row;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic       run_end;
  } brd_out_t;

  // configuration in effective form
  typedef struct packed {
    logic [12:0] endx;
    logic [12:0] endy;
    logic [10:0] ow;
    logic [10:0] oh;
    logic [28:0] xs;
    logic [28:0] ys;
  } brd_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic rows;
    logic col_go;
    logic emit;
    logic row_sel;
    logic commit;
    logic finish;
  } brd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       col_ok;
    logic [1:0] nrows;
    logic       emit_ok;
  } brd_stat_t;

endpackage

[rtl/bilinear_rgb_downscaler.sv]
// top level of the bilinear rgb downscaler: configuration registers and unit wiring
//
// Source pixels enter on the in_ channel in row-major order, one per transaction.
// Each source pixel yields zero to four resampled pixels on the out_ channel, each
// with its destination column and row; run_end marks the last one of a pixel.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user must write
// them only while the block is idle, since the block itself does not enforce it.
// Pixels are processed one at a time by a controller state machine; a pixel gives
// at most two columns of at most two destination rows each, which the sequencer
// walks through a horizontal and a vertical blend and one line store address. A new
// pixel is taken only once the previous one is finished. A result is loaded into the
// output register at the edge that ends the emit of the next result of its pixel,
// or at the end of the pixel, since run_end needs lookahead.
// Reset clears all frame positions and loads the default frame sizes and steps;
// the line store is not cleared. When out_stall is high the result waits in the
// output register and the sequencer pauses before overwriting it; a new pixel can
// still be taken while the last result of the previous one waits there.
module bilinear_rgb_downscaler import brd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  brd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output brd_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [28:0] cfg_wdata
);

  brd_cfg_t    cfg_r, cfg_nxt;
  brd_cmd_t    cmd;
  brd_stat_t   stat;
  logic [12:0] dim_val, dim_end;
  logic [10:0] ow_val;

  // effective last index of a source dimension
  assign dim_val = cfg_wdata[12:0];
  always_comb begin
    priority if (dim_val == 13'd0) begin
      dim_end = 13'd0;
    end else if (14'(dim_val) > 14'(MAX_IN_DIM)) begin
      dim_end = 13'(MAX_IN_DIM - 1);
    end else begin
      dim_end = dim_val - 13'd1;
    end
  end

  assign ow_val = (12'(cfg_wdata[10:0]) > 12'(MAX_OUT_WIDTH)) ? 11'(MAX_OUT_WIDTH)
                                                              : cfg_wdata[10:0];

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_WIDTH:   cfg_nxt.endx = dim_end;
        REG_IN_HEIGHT:  cfg_nxt.endy = dim_end;
        REG_OUT_WIDTH:  cfg_nxt.ow   = ow_val;
        REG_OUT_HEIGHT: cfg_nxt.oh   = cfg_wdata[10:0];
        REG_X_STEP:     cfg_nxt.xs   = cfg_wdata;
        REG_Y_STEP:     cfg_nxt.ys   = cfg_wdata;
        default:        cfg_nxt      = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.endx <= 13'd639;
      cfg_r.endy <= 13'd479;
      cfg_r.ow   <= 11'd256;
      cfg_r.oh   <= 11'd256;
      cfg_r.xs   <= 29'd163840;
      cfg_r.ys   <= 29'd122880;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer
  brd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  brd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[rtl/brd_ram.sv]
// generic single write, single read ram with registered read data
module brd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/brd_ctrl.sv]
// sequencing state machine of the downscaler
module brd_ctrl import brd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  brd_stat_t stat,
  output brd_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_ROWS   = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_WRITE  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   k_r, k_nxt;
  logic   q_r, q_nxt;
  logic   last_emit;

  assign in_stall  = (state_r != S_IDLE);
  assign last_emit = q_r || (stat.nrows == 2'd1);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    q_nxt       = q_r;
    cmd         = '0;
    cmd.row_sel = q_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_ROWS;
      end
      S_ROWS: begin
        cmd.rows  = 1'b1;
        k_nxt     = 1'b0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.col_ok) begin
          cmd.col_go = 1'b1;
          q_nxt      = 1'b0;
          state_nxt  = (stat.nrows == 2'd0) ? S_WRITE : S_EMIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_EMIT: begin
        if (stat.emit_ok) begin
          cmd.emit = 1'b1;
          if (last_emit) begin
            state_nxt = S_WRITE;
          end else begin
            q_nxt = 1'b1;
          end
        end
      end
      S_WRITE: begin
        cmd.commit = 1'b1;
        if (k_r) begin
          state_nxt = S_FINISH;
        end else begin
          k_nxt     = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_FINISH: begin
        if (stat.emit_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= 1'b0;
      q_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      q_r     <= q_nxt;
    end
  end

endmodule

[rtl/brd_dp.sv]
// position tracking, blending, line store and output staging of the downscaler
module brd_dp import brd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  brd_cfg_t  cfg,
  input  brd_in_t   in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output brd_out_t  out_data,
  input  brd_cmd_t  cmd,
  output brd_stat_t stat
);

  // one channel blend: a + floor((b - a) * f / 65536)
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [15:0] f);
    logic signed [8:0]  d;
    logic signed [25:0] prod;
    logic signed [9:0]  sum;
    d    = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = d * $signed({1'b0, f});
    sum  = $signed({2'b00, a}) + $signed(prod[25:16]);
    return sum[7:0];
  endfunction

  function automatic pixel_t lerp_px(input pixel_t a, input pixel_t b, input logic [15:0] f);
    return {lerp8(a[23:16], b[23:16], f), lerp8(a[15:8], b[15:8], f), lerp8(a[7:0], b[7:0], f)};
  endfunction

  // frame position state
  pixel_t      held_r, held_nxt;
  logic [12:0] src_col_r, src_col_nxt;
  logic [12:0] src_row_r, src_row_nxt;
  logic [10:0] next_col_r, next_col_nxt;
  logic [28:0] col_pos_r, col_pos_nxt;
  logic [10:0] next_row_r, next_row_nxt;
  logic [28:0] row_pos_r, row_pos_nxt;

  // per item working registers
  pixel_t      p_r, p_nxt;
  pixel_t      h_r, h_nxt;
  logic [28:0] rpos1_r, rpos1_nxt;
  logic        last_col_r, last_col_nxt;
  logic        last_row_r, last_row_nxt;
  logic [1:0]  nrows_r, nrows_nxt;

  // result staging
  brd_out_t pend_r, pend_nxt;
  logic     pend_valid_r, pend_valid_nxt;
  brd_out_t out_r, out_nxt;
  logic     out_valid_r, out_valid_nxt;

  pixel_t      ls_rdata;
  logic [12:0] yi0, yi1, xi;
  logic        ready0, ready1, ok0, ok1, interior;
  logic [28:0] rp;
  pixel_t      v;
  brd_out_t    res;
  logic        out_free, load_out;

  // line store of the previous resampled row
  brd_ram #(
    .WIDTH (24),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (next_col_r[LS_AW-1:0]),
    .wdata (h_r),
    .raddr (next_col_r[LS_AW-1:0]),
    .rdata (ls_rdata)
  );

  // row readiness
  assign yi0    = row_pos_r[28:16];
  assign yi1    = rpos1_r[28:16];
  assign ready0 = (yi0 < cfg.endy) ? (yi0 < src_row_r) : last_row_r;
  assign ready1 = (yi1 < cfg.endy) ? (yi1 < src_row_r) : last_row_r;
  assign ok0    = (next_row_r < cfg.oh) && ready0;
  assign ok1    = ok0 && ((12'(next_row_r) + 12'd1) < 12'(cfg.oh)) && ready1;

  // column position and interior test for the horizontal blend
  assign xi       = col_pos_r[28:16];
  assign interior = xi < cfg.endx;

  // vertical blend
  assign rp = cmd.row_sel ? rpos1_r : row_pos_r;
  assign v  = (rp[28:16] < cfg.endy) ? lerp_px(ls_rdata, h_r, rp[15:0]) : h_r;

  always_comb begin
    res           = '0;
    res.dst_col   = next_col_r[9:0];
    res.dst_row   = next_row_r[9:0] + {9'd0, cmd.row_sel};
    res.dst_red   = v[23:16];
    res.dst_green = v[15:8];
    res.dst_blue  = v[7:0];
    res.run_end   = 1'b0;
  end

  // status
  assign out_free     = !out_valid_r || !out_stall;
  assign stat.col_ok  = (next_col_r < cfg.ow) && (interior ? (xi < src_col_r) : last_col_r);
  assign stat.nrows   = nrows_r;
  assign stat.emit_ok = !pend_valid_r || out_free;

  // working register updates
  always_comb begin
    p_nxt        = cmd.capture ? pixel_t'(in_data) : p_r;
    rpos1_nxt    = cmd.prep ? (row_pos_r + cfg.ys) : rpos1_r;
    last_col_nxt = cmd.prep ? (src_col_r >= cfg.endx) : last_col_r;
    last_row_nxt = cmd.prep ? (src_row_r >= cfg.endy) : last_row_r;
    h_nxt        = h_r;
    if (cmd.col_go) begin
      h_nxt = interior ? lerp_px(held_r, p_r, col_pos_r[15:0]) : p_r;
    end
  end

  always_comb begin
    nrows_nxt = nrows_r;
    if (cmd.rows) begin
      nrows_nxt = ok1 ? 2'd2 : (ok0 ? 2'd1 : 2'd0);
    end
  end

  // position state updates
  always_comb begin
    held_nxt     = held_r;
    src_col_nxt  = src_col_r;
    src_row_nxt  = src_row_r;
    next_col_nxt = next_col_r;
    col_pos_nxt  = col_pos_r;
    next_row_nxt = next_row_r;
    row_pos_nxt  = row_pos_r;
    if (cmd.commit) begin
      next_col_nxt = next_col_r + 11'd1;
      col_pos_nxt  = col_pos_r + cfg.xs;
    end
    if (cmd.finish) begin
      held_nxt = p_r;
      if (last_col_r) begin
        next_col_nxt = '0;
        col_pos_nxt  = '0;
        src_col_nxt  = '0;
        if (last_row_r) begin
          src_row_nxt  = '0;
          next_row_nxt = '0;
          row_pos_nxt  = '0;
        end else begin
          src_row_nxt  = src_row_r + 13'd1;
          next_row_nxt = next_row_r + {9'd0, nrows_r};
          unique case (nrows_r)
            2'd0:    row_pos_nxt = row_pos_r;
            2'd1:    row_pos_nxt = rpos1_r;
            default: row_pos_nxt = rpos1_r + cfg.ys;
          endcase
        end
      end else begin
        src_col_nxt = src_col_r + 13'd1;
      end
    end
  end

  // pending result and output register
  assign load_out = (cmd.emit || cmd.finish) && pend_valid_r;

  always_comb begin
    pend_nxt       = cmd.emit ? res : pend_r;
    pend_valid_nxt = pend_valid_r;
    if (cmd.emit) begin
      pend_valid_nxt = 1'b1;
    end else if (cmd.finish) begin
      pend_valid_nxt = 1'b0;
    end
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_nxt         = pend_r;
      out_nxt.run_end = cmd.finish;
      out_valid_nxt   = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // control and position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      src_col_r    <= '0;
      src_row_r    <= '0;
      next_col_r   <= '0;
      col_pos_r    <= '0;
      next_row_r   <= '0;
      row_pos_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      src_col_r    <= src_col_nxt;
      src_row_r    <= src_row_nxt;
      next_col_r   <= next_col_nxt;
      col_pos_r    <= col_pos_nxt;
      next_row_r   <= next_row_nxt;
      row_pos_r    <= row_pos_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    h_r        <= h_nxt;
    rpos1_r    <= rpos1_nxt;
    last_col_r <= last_col_nxt;
    last_row_r <= last_row_nxt;
    nrows_r    <= nrows_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

endmodule

[verif/bilinear_rgb_downscaler_tb.sv]
// self-checking testbench of the bilinear rgb downscaler with a frame-level scoreboard
module bilinear_rgb_downscaler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brd_pkg::*;

  localparam int          HALF_PERIOD   = 4;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          LONG_HOLD     = 400;
  localparam int unsigned FX_ONE        = 32'h10000;
  localparam int unsigned STEP_MAX      = 32'h1FFFFFFF;

  // predicts the resampled pixels of each source pixel and matches them in order
  class resize_scoreboard;
    logic [12:0] in_w_reg, in_h_reg;
    logic [10:0] out_w_reg, out_h_reg;
    logic [28:0] x_step_reg, y_step_reg;
    pixel_t      row_buf [MAX_OUT_WIDTH];
    pixel_t      prev_px;
    int unsigned col_in, row_in, col_out, row_out;
    logic [28:0] col_acc, row_acc;
    brd_out_t    expected_px [$];
    brd_out_t    last_px;
    bit          last_valid;
    int          errors;

    function new();
      in_w_reg   = 13'd640;
      in_h_reg   = 13'd480;
      out_w_reg  = 11'd256;
      out_h_reg  = 11'd256;
      x_step_reg = 29'd163840;
      y_step_reg = 29'd122880;
      foreach (row_buf[i]) row_buf[i] = '0;
      prev_px    = '0;
      col_in     = 0;
      row_in     = 0;
      col_out    = 0;
      row_out    = 0;
      col_acc    = '0;
      row_acc    = '0;
      last_valid = 1'b0;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(logic [2:0] idx, logic [28:0] val);
      case (idx)
        REG_IN_WIDTH:   in_w_reg   = val[12:0];
        REG_IN_HEIGHT:  in_h_reg   = val[12:0];
        REG_OUT_WIDTH:  out_w_reg  = val[10:0];
        REG_OUT_HEIGHT: out_h_reg  = val[10:0];
        REG_X_STEP:     x_step_reg = val;
        REG_Y_STEP:     y_step_reg = val;
        default: ;
      endcase
    endfunction

    // zero acts as one, large sizes saturate
    function int unsigned eff_dim(logic [12:0] v);
      if (v == 0) return 1;
      if (v > MAX_IN_DIM) return MAX_IN_DIM;
      return 32'(v);
    endfunction

    // per channel (a*(1-f) + b*f) >> 16
    function pixel_t blend(pixel_t a, pixel_t b, logic [15:0] frac);
      pixel_t      mix;
      int unsigned ca, cb, wa;
      wa = FX_ONE - 32'(frac);
      for (int sh = 0; sh < 24; sh += 8) begin
        ca = 32'(a[sh +: 8]);
        cb = 32'(b[sh +: 8]);
        mix[sh +: 8] = 8'((ca * wa + cb * 32'(frac)) >> 16);
      end
      return mix;
    endfunction

    function bit row_due(logic [28:0] pos, int unsigned endy, bit last_row);
      int unsigned yi;
      yi = 32'(pos[28:16]);
      if (yi < endy) return yi < row_in;
      return last_row;
    endfunction

    // accepted source pixel: work out the destination pixels it releases
    task note_input(brd_in_t px);
      pixel_t      p, h, v;
      int unsigned endx, endy, ow, oh, xi, nrows;
      bit          last_col, last_row;
      logic [28:0] rpos [2];
      int unsigned ridx [2];
      brd_out_t    r;
      p        = px;
      endx     = eff_dim(in_w_reg) - 1;
      endy     = eff_dim(in_h_reg) - 1;
      ow       = (out_w_reg > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : 32'(out_w_reg);
      oh       = 32'(out_h_reg);
      last_col = col_in >= endx;
      last_row = row_in >= endy;
      rpos[0]  = row_acc;
      rpos[1]  = row_acc + y_step_reg;
      ridx[0]  = row_out;
      ridx[1]  = row_out + 1;

      // up to two destination rows served by this source row
      nrows = 0;
      for (int q = 0; q < 2; q++) begin
        if (nrows != q || ridx[q] >= oh || !row_due(rpos[q], endy, last_row)) break;
        nrows++;
      end

      // up to two columns per source pixel, each emitted for every ready row
      for (int k = 0; k < 2 && col_out < ow; k++) begin
        xi = 32'(col_acc[28:16]);
        if (xi < endx) begin
          if (xi >= col_in) break;
          h = blend(prev_px, p, col_acc[15:0]);
        end else begin
          if (!last_col) break;
          h = p;
        end
        for (int q = 0; q < nrows; q++) begin
          v = (rpos[q][28:16] < endy) ? blend(row_buf[col_out], h, rpos[q][15:0]) : h;
          r.dst_col = col_out[9:0];
          r.dst_row = ridx[q][9:0];
          {r.dst_red, r.dst_green, r.dst_blue} = v;
          r.run_end = 1'b0;
          if (last_valid) expected_px.push_back(last_px);
          last_px    = r;
          last_valid = 1'b1;
        end
        row_buf[col_out] = h;
        col_out++;
        col_acc = col_acc + x_step_reg;
      end

      // last result of this pixel carries run_end
      if (last_valid) begin
        last_px.run_end = 1'b1;
        expected_px.push_back(last_px);
        last_valid = 1'b0;
      end

      // advance the frame position
      prev_px = p;
      if (last_col) begin
        col_out = 0;
        col_acc = '0;
        col_in  = 0;
        if (last_row) begin
          row_in  = 0;
          row_out = 0;
          row_acc = '0;
        end else begin
          row_in++;
          row_out = (row_out + nrows) & 32'h7FF;
          row_acc = 29'(row_acc + nrows * y_step_reg);
        end
      end else begin
        col_in++;
      end
    endtask

    task check_result(brd_out_t got);
      brd_out_t want;
      if (expected_px.size() == 0) begin
        report($sformatf("unexpected transaction col %0d row %0d", got.dst_col, got.dst_row));
        return;
      end
      want = expected_px.pop_front();
      if (got.dst_col !== want.dst_col)
        report($sformatf("dst_col %0d, want %0d", got.dst_col, want.dst_col));
      if (got.dst_row !== want.dst_row)
        report($sformatf("dst_row %0d, want %0d", got.dst_row, want.dst_row));
      if (got.dst_red !== want.dst_red)
        report($sformatf("dst_red %0h, want %0h", got.dst_red, want.dst_red));
      if (got.dst_green !== want.dst_green)
        report($sformatf("dst_green %0h, want %0h", got.dst_green, want.dst_green));
      if (got.dst_blue !== want.dst_blue)
        report($sformatf("dst_blue %0h, want %0h", got.dst_blue, want.dst_blue));
      if (got.run_end !== want.run_end)
        report($sformatf("run_end %0b, want %0b", got.run_end, want.run_end));
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  brd_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  brd_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = REG_IN_WIDTH;
  logic [28:0] cfg_wdata = '0;

  resize_scoreboard sb;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  bit hold_req        = 1'b0;
  int hold_left       = 0;
  int cycle_count     = 0;

  bilinear_rgb_downscaler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check each transaction, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) hold_left--;
    out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // write all six registers, one per cycle
  task automatic configure(int unsigned in_w, int unsigned in_h, int unsigned out_w,
                           int unsigned out_h, int unsigned xs, int unsigned ys);
    logic [2:0]  idx  [6] = '{REG_IN_WIDTH, REG_IN_HEIGHT, REG_OUT_WIDTH,
                              REG_OUT_HEIGHT, REG_X_STEP, REG_Y_STEP};
    logic [28:0] vals [6];
    vals[0] = 29'(in_w);
    vals[1] = 29'(in_h);
    vals[2] = 29'(out_w);
    vals[3] = 29'(out_h);
    vals[4] = 29'(xs);
    vals[5] = 29'(ys);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      sb.set_reg(idx[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // stop sending and wait until the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one input transaction with optional idle cycles ahead of it
  task automatic send_pixel(brd_in_t px);
    bit idled;
    idled = 1'b0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      if (!idled) in_valid <= 1'b0;
      idled = 1'b1;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(px);
  endtask

  // a whole frame of random pixels, optionally pausing halfway until drained
  task automatic send_frame(int npix, bit mid_pause);
    brd_in_t px;
    for (int i = 0; i < npix; i++) begin
      if (mid_pause && i == npix / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_px.size() != 0) @(posedge clk);
      end
      px = 24'($urandom);
      if ($urandom_range(0, 7) == 0) px = '0;
      else if ($urandom_range(0, 7) == 0) px = '1;
      send_pixel(px);
    end
  endtask

  // small random frame geometries, each kept for one or two frames
  task automatic random_frames(int target);
    int          sent, nfr;
    int unsigned in_w, in_h, ew, eh, out_w, out_h, xs, ys;
    sent = 0;
    while (sent < target) begin
      in_w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
      in_h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      ew    = sb.eff_dim(13'(in_w));
      eh    = sb.eff_dim(13'(in_h));
      case ($urandom_range(0, 9))
        0:       out_w = 0;
        1:       out_w = $urandom_range(1025, 2047);
        2:       out_w = ew + $urandom_range(1, 3);
        default: out_w = $urandom_range(1, ew);
      endcase
      case ($urandom_range(0, 9))
        0:       out_h = 0;
        1:       out_h = $urandom_range(1025, 2047);
        2:       out_h = eh + $urandom_range(1, 3);
        default: out_h = $urandom_range(1, eh);
      endcase
      xs = (ew * FX_ONE) / ((out_w == 0) ? 1 : out_w);
      ys = (eh * FX_ONE) / ((out_h == 0) ? 1 : out_h);
      if ($urandom_range(0, 3) == 0)
        xs = $urandom_range(0, 1) ? $urandom_range(0, STEP_MAX) : $urandom_range(0, 3 * FX_ONE);
      if ($urandom_range(0, 3) == 0)
        ys = $urandom_range(0, 1) ? $urandom_range(0, STEP_MAX) : $urandom_range(0, 3 * FX_ONE);
      settle();
      configure(in_w, in_h, out_w, out_h, xs, ys);
      nfr = $urandom_range(1, 2);
      repeat (nfr) begin
        send_frame(ew * eh, 1'b0);
        sent += ew * eh;
      end
    end
  endtask

  initial begin
    brd_in_t corner_px [12] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                24'h0000FF, 24'hAA55AA, 24'h55AA55, 24'hFFFFFF,
                                24'h000000, 24'h123456, 24'hFEDCBA, 24'h808080};
    brd_in_t burst_px  [4]  = '{24'hFFFFFF, 24'h000000, 24'h00FF00, 24'hFF00FF};
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // 4x3 down to 2x2 with extreme and checkerboard colors
    configure(4, 3, 2, 2, 2 * FX_ONE, 3 * FX_ONE / 2);
    foreach (corner_px[i]) send_pixel(corner_px[i]);

    // zero x step: two columns from the second pixel of each row, two rows from the last source row, the rest dropped
    settle();
    configure(2, 2, 5, 3, 0, FX_ONE / 2);
    foreach (burst_px[i]) send_pixel(burst_px[i]);

    // empty destination: nothing comes out
    settle();
    configure(2, 2, 0, 0, FX_ONE, FX_ONE);
    foreach (burst_px[i]) send_pixel(burst_px[i]);

    // long receiver hold-off while the sender keeps offering, then a drain pause
    settle();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    configure(8, 4, 8, 4, FX_ONE, FX_ONE);
    hold_req = 1'b1;
    send_frame(32, 1'b1);

    // widest source, single row, saturated output width and largest y step, first part only
    settle();
    configure(8191, 0, 2047, 2047, FX_ONE, STEP_MAX);
    send_frame(32, 1'b0);

    // single column, tallest source, first rows only
    settle();
    configure(0, 8191, 1, 2047, STEP_MAX, FX_ONE);
    send_frame(24, 1'b0);

    // random frames under each idling pattern
    random_frames(40);
    sender_idle_pct = 74;
    random_frames(40);
    sender_idle_pct = 0;
    recv_stall_pct  = 74;
    random_frames(40);
    sender_idle_pct = 8;
    recv_stall_pct  = 8;
    random_frames(40);

    settle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
